### rtl/glcd_tcs_pkg.sv
// Package: shared types, command codes and the 5x7 font ROM for the text sequencer.
package glcd_tcs_pkg;

    localparam int HALF_COLUMNS = 64;
    localparam int PAGE_COUNT   = 8;

    localparam logic [7:0] CMD_SET_PAGE = 8'hB8;
    localparam logic [7:0] CMD_SET_COL  = 8'h40;
    localparam logic [7:0] FIRST_CHAR   = 8'd32;
    localparam logic [7:0] LAST_CHAR    = 8'd90;
    localparam logic [7:0] BLANK_BYTE   = 8'h00;

    localparam logic [2:0] BLANK_IDX    = 3'd5;
    localparam logic [2:0] DONE_IDX     = 3'd6;
    localparam logic [7:0] COL_BEFORE_HALF = 8'(HALF_COLUMNS - 1);

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAGE,
        ST_COL,
        ST_DATA,
        ST_XPAGE,
        ST_XCOL
    } state_t;

    typedef enum logic [2:0] {
        WR_PAGE,
        WR_COL,
        WR_DATA,
        WR_XPAGE,
        WR_XCOL
    } wr_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     emit;
        wr_kind_t kind;
        logic     last;
        logic     wrap;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic in_set;
        logic in_char_ok;
        logic set_req;
        logic hit_half;
        logic glyph_last;
        logic glyph_end;
    } dp_stat_t;

    // Five glyph columns packed with column 0 in the top byte
    function automatic logic [39:0] glyph_row(input logic [7:0] code);
        logic [39:0] row;
        case (code)
            8'd32: row = 40'h00_00_00_00_00;
            8'd33: row = 40'h00_00_5F_00_00;
            8'd34: row = 40'h00_07_00_07_00;
            8'd35: row = 40'h14_7F_14_7F_14;
            8'd36: row = 40'h24_2A_7F_2A_12;
            8'd37: row = 40'h23_13_08_64_62;
            8'd38: row = 40'h36_49_55_22_50;
            8'd39: row = 40'h00_05_03_00_00;
            8'd40: row = 40'h00_1C_22_41_00;
            8'd41: row = 40'h00_41_22_1C_00;
            8'd42: row = 40'h14_08_3E_08_14;
            8'd43: row = 40'h08_08_3E_08_08;
            8'd44: row = 40'h00_50_30_00_00;
            8'd45: row = 40'h08_08_08_08_08;
            8'd46: row = 40'h00_60_60_00_00;
            8'd47: row = 40'h20_10_08_04_02;
            8'd48: row = 40'h3E_51_49_45_3E;
            8'd49: row = 40'h00_42_7F_40_00;
            8'd50: row = 40'h42_61_51_49_46;
            8'd51: row = 40'h21_41_45_4B_31;
            8'd52: row = 40'h18_14_12_7F_10;
            8'd53: row = 40'h27_45_45_45_39;
            8'd54: row = 40'h3C_4A_49_49_30;
            8'd55: row = 40'h01_71_09_05_03;
            8'd56: row = 40'h36_49_49_49_36;
            8'd57: row = 40'h06_49_49_29_1E;
            8'd58: row = 40'h00_36_36_00_00;
            8'd59: row = 40'h00_56_36_00_00;
            8'd60: row = 40'h08_14_22_41_00;
            8'd61: row = 40'h14_14_14_14_14;
            8'd62: row = 40'h00_41_22_14_08;
            8'd63: row = 40'h02_01_51_09_06;
            8'd64: row = 40'h32_49_79_41_3E;
            8'd65: row = 40'h7E_11_11_11_7E;
            8'd66: row = 40'h7F_49_49_49_36;
            8'd67: row = 40'h3E_41_41_41_22;
            8'd68: row = 40'h7F_41_41_22_1C;
            8'd69: row = 40'h7F_49_49_49_41;
            8'd70: row = 40'h7F_09_09_09_01;
            8'd71: row = 40'h3E_41_49_49_7A;
            8'd72: row = 40'h7F_08_08_08_7F;
            8'd73: row = 40'h00_41_7F_41_00;
            8'd74: row = 40'h20_40_41_3F_01;
            8'd75: row = 40'h7F_08_14_22_41;
            8'd76: row = 40'h7F_40_40_40_40;
            8'd77: row = 40'h7F_02_0C_02_7F;
            8'd78: row = 40'h7F_04_08_10_7F;
            8'd79: row = 40'h3E_41_41_41_3E;
            8'd80: row = 40'h7F_09_09_09_06;
            8'd81: row = 40'h3E_41_51_21_5E;
            8'd82: row = 40'h7F_09_19_29_46;
            8'd83: row = 40'h26_49_49_49_32;
            8'd84: row = 40'h01_01_7F_01_01;
            8'd85: row = 40'h3F_40_40_40_3F;
            8'd86: row = 40'h1F_20_40_20_1F;
            8'd87: row = 40'h7F_20_18_20_7F;
            8'd88: row = 40'h63_14_08_14_63;
            8'd89: row = 40'h07_08_70_08_07;
            8'd90: row = 40'h61_51_49_45_43;
            default: row = 40'h00_00_00_00_00;
        endcase
        return row;
    endfunction

endpackage

### rtl/glcd_tcs_if.sv
// Interfaces: request channel and display bus write channel.
interface glcd_tcs_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_code;
    logic [2:0] target_page;
    logic [6:0] target_column;

    modport source (output valid, req_type, char_code, target_page, target_column,
                    input ready);
    modport sink   (input valid, req_type, char_code, target_page, target_column,
                    output ready);
endinterface

interface glcd_tcs_wr_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic       right_half;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, is_data, right_half, bus_byte, last, input ready);
    modport sink   (input valid, is_data, right_half, bus_byte, last, output ready);
endinterface

### rtl/glcd_tcs_ctrl.sv
// Controller: sequences the bus writes of one request.
module glcd_tcs_ctrl
    import glcd_tcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = WR_PAGE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    // out-of-range characters finish here with no writes
                    if (stat.in_set || stat.in_char_ok)
                    begin
                        state_next = ST_PAGE;
                    end
                end
            end
            ST_PAGE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = WR_PAGE;
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = WR_COL;
                    cmd.last   = stat.set_req;
                    state_next = stat.set_req ? ST_IDLE : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = WR_DATA;
                    cmd.last = stat.glyph_last && !stat.hit_half;
                    cmd.wrap = stat.glyph_last && !stat.hit_half;
                    if (stat.hit_half)
                    begin
                        state_next = ST_XPAGE;
                    end
                    else if (stat.glyph_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PAGE;
                    end
                end
            end
            ST_XPAGE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = WR_XPAGE;
                    state_next = ST_XCOL;
                end
            end
            ST_XCOL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = WR_XCOL;
                    cmd.last   = stat.glyph_end;
                    cmd.wrap   = stat.glyph_end;
                    state_next = stat.glyph_end ? ST_IDLE : ST_PAGE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/glcd_tcs_dp.sv
// Datapath: cursor, glyph column counter, byte formation and output register.
module glcd_tcs_dp
    import glcd_tcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_type,
    input  logic [7:0] char_code,
    input  logic [2:0] target_page,
    input  logic [6:0] target_column,
    input  ctl_cmd_t   cmd,
    output dp_stat_t   stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_data,
    output logic       right_half,
    output logic [7:0] bus_byte,
    output logic       last
);

    logic [2:0] page_reg;
    logic [2:0] page_next;
    logic [7:0] col_reg;
    logic [7:0] col_next;
    logic [7:0] col_inc;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [7:0] code_reg;
    logic       set_req_reg;
    logic       valid_reg;
    logic       is_data_reg;
    logic       right_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic [39:0] row;
    logic [7:0]  glyph_byte;
    logic        wr_right;
    logic [7:0]  wr_byte;
    logic        wr_is_data;

    // Status toward the controller
    assign stat.out_free   = !valid_reg || out_ready;
    assign stat.in_set     = (req_type == REQ_SET);
    assign stat.in_char_ok = (char_code >= FIRST_CHAR) && (char_code <= LAST_CHAR);
    assign stat.set_req    = set_req_reg;
    assign stat.hit_half   = (col_reg == COL_BEFORE_HALF);
    assign stat.glyph_last = (idx_reg == BLANK_IDX);
    assign stat.glyph_end  = (idx_reg == DONE_IDX);

    // Glyph column select; the sixth column is blank
    always_comb
    begin
        row = glyph_row(code_reg);
        case (idx_reg)
            3'd0:    glyph_byte = row[39:32];
            3'd1:    glyph_byte = row[31:24];
            3'd2:    glyph_byte = row[23:16];
            3'd3:    glyph_byte = row[15:8];
            3'd4:    glyph_byte = row[7:0];
            default: glyph_byte = BLANK_BYTE;
        endcase
    end

    // Bus write formation
    always_comb
    begin
        wr_right   = col_reg[7] | col_reg[6];
        wr_is_data = 1'b0;
        case (cmd.kind)
            WR_PAGE:  wr_byte = CMD_SET_PAGE | {5'd0, page_reg};
            WR_COL:   wr_byte = CMD_SET_COL | {2'd0, col_reg[5:0]};
            WR_DATA:
            begin
                wr_byte    = glyph_byte;
                wr_is_data = 1'b1;
            end
            WR_XPAGE:
            begin
                wr_byte  = CMD_SET_PAGE | {5'd0, page_reg};
                wr_right = 1'b1;
            end
            WR_XCOL:
            begin
                wr_byte  = CMD_SET_COL;
                wr_right = 1'b1;
            end
            default:  wr_byte = BLANK_BYTE;
        endcase
    end

    // Cursor update: advance on data, wrap at line end after the character
    always_comb
    begin
        page_next = page_reg;
        idx_next  = idx_reg;
        col_inc   = col_reg;
        if (cmd.emit && cmd.kind == WR_DATA)
        begin
            col_inc  = col_reg + 8'd1;
            idx_next = idx_reg + 3'd1;
        end
        col_next = col_inc;
        if (cmd.wrap && col_inc[7])
        begin
            col_next  = 8'd0;
            page_next = page_reg + 3'd1;
        end
        if (cmd.accept)
        begin
            idx_next = 3'd0;
            if (req_type == REQ_SET)
            begin
                page_next = target_page;
                col_next  = {1'b0, target_column};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= 3'd0;
            col_reg   <= 8'd0;
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            page_reg <= page_next;
            col_reg  <= col_next;
            idx_reg  <= idx_next;
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Request latch and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg    <= char_code;
            set_req_reg <= req_type;
        end
        if (cmd.emit)
        begin
            is_data_reg <= wr_is_data;
            right_reg   <= wr_right;
            byte_reg    <= wr_byte;
            last_reg    <= cmd.last;
        end
    end

    assign out_valid  = valid_reg;
    assign is_data    = is_data_reg;
    assign right_half = right_reg;
    assign bus_byte   = byte_reg;
    assign last       = last_reg;

endmodule

### rtl/glcd_text_cursor_sequencer.sv
// Top level: text cursor sequencer for a two-controller 128x64 display.
//
//  channel  dir  transfer        payload
//  req      in   one request     req_type, char_code, target_page, target_column
//  wr       out  one bus write   is_data, right_half, bus_byte, last
//
// A set-cursor request gives 2 bus writes, a drawn character 18, or 20 when it
// crosses column 64. The write rate is set by the single output register: one
// write per cycle while wr.ready is high; a low wr.ready holds the controller in
// place. A new request is taken only once the previous one has issued its last
// write. Reset puts the cursor at page 0, column 0, with no write pending.
module glcd_text_cursor_sequencer
    import glcd_tcs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    glcd_tcs_req_if.sink req,
    glcd_tcs_wr_if.source wr
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    glcd_tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    glcd_tcs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req.req_type),
        .char_code     (req.char_code),
        .target_page   (req.target_page),
        .target_column (req.target_column),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (wr.valid),
        .out_ready     (wr.ready),
        .is_data       (wr.is_data),
        .right_half    (wr.right_half),
        .bus_byte      (wr.bus_byte),
        .last          (wr.last)
    );

endmodule

### rtl/glcd_tcs_chk.sv
// Checker: port-level properties of the text sequencer, bound to the top level.
module glcd_tcs_chk
    import glcd_tcs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_type,
    input logic       wr_valid,
    input logic       wr_ready,
    input logic       is_data,
    input logic [7:0] bus_byte,
    input logic       last
);

    // A stalled write holds its byte and last flag
    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid && $stable(bus_byte) && $stable(last))
        else $error("stalled bus write changed");

    // A set-cursor transfer always starts a write sequence
    a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_SET |=> !req_ready)
        else $error("set-cursor request did not start a sequence");

    // Only the closing write of a request may be pending while a request is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !last |-> !req_ready)
        else $error("request taken before sequence finished");

    // A nonblank glyph byte is never the closing write
    a_glyph_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && is_data && bus_byte != BLANK_BYTE |-> !last)
        else $error("glyph column marked as last");

endmodule

bind glcd_text_cursor_sequencer glcd_tcs_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .wr_valid  (wr.valid),
    .wr_ready  (wr.ready),
    .is_data   (wr.is_data),
    .bus_byte  (wr.bus_byte),
    .last      (wr.last)
);

### test/glcd_tcs_checker.sv
// Bus write checker: predicts the display writes of each request and compares them.
`timescale 1ns / 1ps

module glcd_tcs_checker
    import glcd_tcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    glcd_tcs_req_if req,
    glcd_tcs_wr_if  wr,
    output int     error_count,
    output int     writes_pending
);

    localparam logic [7:0] LINE_COLUMNS = 8'(2 * HALF_COLUMNS);

    typedef struct packed {
        logic       is_data;
        logic       right_half;
        logic [7:0] bus_byte;
        logic       last;
    } bus_write_t;

    // 5x7 font for codes 32..90, glyph column 0 in the top byte
    localparam logic [39:0] FONT [59] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h2649494932, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h7F2018207F, 40'h6314081463, 40'h0708700807, 40'h6151494543
    };

    // Predicted cursor and the writes still owed by the block
    logic [2:0]  cursor_page;
    logic [7:0]  cursor_column;
    bus_write_t  expected_writes [$];
    bus_write_t  oldest;
    int          mismatches = 0;

    task automatic queue_write(input logic data, input logic right, input logic [7:0] value);
        bus_write_t w;
        w.is_data    = data;
        w.right_half = right;
        w.bus_byte   = value;
        w.last       = 1'b0;
        expected_writes.push_back(w);
    endtask

    // Set-page then set-column, both to the half that owns the column
    task automatic queue_position(input logic [2:0] page, input logic [7:0] col);
        logic right;
        right = (col >= HALF_COLUMNS);
        queue_write(1'b0, right, CMD_SET_PAGE | {5'b0, page});
        queue_write(1'b0, right, CMD_SET_COL | 8'(col % HALF_COLUMNS));
    endtask

    // One glyph column: position, data byte, advance; re-home the right half at 64
    task automatic queue_glyph_column(input logic [7:0] value);
        logic [7:0] col;
        col = cursor_column;
        queue_position(cursor_page, col);
        queue_write(1'b1, col >= HALF_COLUMNS, value);
        cursor_column = col + 8'd1;
        if (cursor_column == HALF_COLUMNS) begin
            queue_write(1'b0, 1'b1, CMD_SET_PAGE | {5'b0, cursor_page});
            queue_write(1'b0, 1'b1, CMD_SET_COL);
        end
    endtask

    task automatic predict_writes(input logic rtype, input logic [7:0] code,
                                  input logic [2:0] page, input logic [6:0] col);
        int          first;
        logic [39:0] glyph;
        bus_write_t  w;
        first = expected_writes.size();
        if (rtype == REQ_SET) begin
            cursor_page   = page;
            cursor_column = {1'b0, col};
            queue_position(cursor_page, cursor_column);
        end
        else if (code >= FIRST_CHAR && code <= LAST_CHAR) begin
            glyph = FONT[code - FIRST_CHAR];
            for (int i = 0; i < 5; i++)
                queue_glyph_column(glyph[39 - 8 * i -: 8]);
            queue_glyph_column(BLANK_BYTE);
            // line wrap only once the whole character is out
            if (cursor_column >= LINE_COLUMNS) begin
                cursor_column = '0;
                cursor_page   = 3'((cursor_page + 1) % PAGE_COUNT);
            end
        end
        if (expected_writes.size() > first) begin
            w = expected_writes.pop_back();
            w.last = 1'b1;
            expected_writes.push_back(w);
        end
    endtask

    task automatic check_field(input string what, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expected,
                     actual);
            mismatches++;
        end
    endtask

    // Predict on request transfers, compare on write transfers
    always @(posedge clk) begin
        if (!rst_n) begin
            cursor_page   = '0;
            cursor_column = '0;
            expected_writes.delete();
        end
        else begin
            if (req.valid && req.ready)
                predict_writes(req.req_type, req.char_code, req.target_page,
                               req.target_column);
            if (wr.valid && wr.ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected bus write, expected none, actual %b %b %h %b",
                             $time, wr.is_data, wr.right_half, wr.bus_byte, wr.last);
                    mismatches++;
                end
                else begin
                    oldest = expected_writes.pop_front();
                    check_field("is_data", oldest.is_data, wr.is_data);
                    check_field("right_half", oldest.right_half, wr.right_half);
                    check_field("bus_byte", oldest.bus_byte, wr.bus_byte);
                    check_field("last", oldest.last, wr.last);
                end
            end
        end
        writes_pending <= expected_writes.size();
        error_count    <= mismatches;
    end

endmodule

### test/tb.sv
// Testbench top: clock, reset, request and bus-ready stimulus, and the verdict.
`timescale 1ns / 1ps

module tb;
    import glcd_tcs_pkg::*;

    localparam int ITEM_TARGET     = 430;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RESET_CYCLES    = 5;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;
    int   error_count;
    int   writes_pending;
    int   cycle_count = 0;

    // Stimulus shaping shared by the two sides; hold_issued is request side only
    bit   quiet         = 1'b0;
    bit   hold_off_req  = 1'b0;
    bit   hold_active   = 1'b0;
    bit   hold_issued   = 1'b0;

    glcd_tcs_req_if req_bus ();
    glcd_tcs_wr_if  wr_bus ();

    glcd_text_cursor_sequencer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .wr    (wr_bus)
    );

    glcd_tcs_checker u_write_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .wr             (wr_bus),
        .error_count    (error_count),
        .writes_pending (writes_pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Run limit
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d writes pending", $time, cycle_count,
                 writes_pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Columns weighted toward the half boundary and the line end
    function automatic logic [6:0] pick_column();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 7'($urandom_range(0, 127));
        if (roll < 75)
            return 7'($urandom_range(56, 64));
        return 7'($urandom_range(118, 127));
    endfunction

    // One request transfer; valid stays high when the next one follows at once
    task automatic send_request(input logic rtype, input logic [7:0] code,
                                input logic [2:0] page, input logic [6:0] col);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= rtype;
        req_bus.char_code     <= code;
        req_bus.target_page   <= page;
        req_bus.target_column <= col;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    task automatic send_set(input logic [2:0] page, input logic [6:0] col);
        send_request(REQ_SET, 8'($urandom), page, col);
    endtask

    task automatic send_char(input logic [7:0] code);
        send_request(REQ_DRAW, code, 3'($urandom), 7'($urandom));
    endtask

    // Bus side: random ready stalls, plus one long hold-off on request
    initial begin
        int stall;
        wr_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                wr_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_active  = 1'b0;
            end
            else begin
                stall = pick_idle();
                if (stall > 0) begin
                    wr_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            wr_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Request side and verdict
    initial begin
        int   counted;
        int   roll;
        logic [7:0] code;
        counted = 0;
        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_DRAW;
        req_bus.char_code     <= '0;
        req_bus.target_page   <= '0;
        req_bus.target_column <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: font ends, ignored codes, half crossing, line and page wrap
        send_char(FIRST_CHAR);
        send_char(LAST_CHAR);
        send_char(FIRST_CHAR - 8'd1);
        send_char(LAST_CHAR + 8'd1);
        send_char(8'd0);
        send_char(8'd255);
        send_set(3'd0, 7'd63);
        send_char(8'd65);
        send_set(3'd2, 7'd58);
        send_char(8'd72);
        send_set(3'd7, 7'd127);
        send_char(8'd77);
        send_set(3'd5, 7'd122);
        send_char(8'd48);
        send_set(3'd3, 7'd64);
        send_char(8'd33);
        send_set(3'd7, 7'd0);
        send_char(8'd89);
        send_set(3'd0, 7'd123);
        send_char(8'd50);
        send_char(8'd51);
        send_set(3'd7, 7'd122);
        send_char(8'd87);

        // Random: mostly legal text, some cursor moves, a little ignored noise
        while (counted < ITEM_TARGET) begin
            if (counted == 300 && !hold_issued) begin
                hold_issued  = 1'b1;
                hold_off_req = 1'b1;
            end
            quiet = (counted >= 150 && counted < 200) || hold_off_req || hold_active;
            roll  = $urandom_range(0, 99);
            if (roll < 8) begin
                code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                            : 8'($urandom_range(91, 255));
                send_char(code);
                counted++;
            end
            else if (roll < 22) begin
                send_set(3'($urandom), pick_column());
                counted++;
            end
            else begin
                send_char(8'($urandom_range(FIRST_CHAR, LAST_CHAR)));
                counted++;
            end
        end
        quiet = 1'b0;
        req_bus.valid <= 1'b0;

        // Drain: wait for every owed write, then idle on before the verdict
        @(posedge clk);
        while (writes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && writes_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/glcd_tcs_pkg.sv
rtl/glcd_tcs_if.sv
rtl/glcd_tcs_ctrl.sv
rtl/glcd_tcs_dp.sv
rtl/glcd_text_cursor_sequencer.sv
rtl/glcd_tcs_chk.sv
test/glcd_tcs_checker.sv
test/tb.sv
